// ----- hw/rtl/slvf_pkg.sv -----
// Shared types, constants and table functions for the segment LCD value framer.
// Used by slvf_digit, slvf_seq, segment_lcd_value_framer and slvf_checker.
// Depends on nothing.
package slvf_pkg;

	// Default number of displayed decimal digits.
	localparam int DIGIT_COUNT = 4;

	// Frame prefixes, lengths and the point segment bit.
	localparam logic [2:0] DATA_PREFIX = 3'b101;
	localparam logic [3:0] CMD_PREFIX  = 4'b1000;
	localparam logic [3:0] DATA_LEN    = 4'd13;
	localparam logic [3:0] CMD_LEN     = 4'd12;
	localparam logic [7:0] POINT_BIT   = 8'h10;

	// Largest power of ten whose multiples can still fit under a 16-bit value.
	localparam logic [2:0] MAX_POW_SEL = 3'd4;

	// Request as held in the input register.
	typedef struct packed {
		logic        req_type;
		logic [15:0] value;
		logic        point_on;
		logic [7:0]  command_code;
	} req_t;

	// One outgoing frame.
	typedef struct packed {
		logic [12:0] word;
		logic [3:0]  length;
		logic        last;
	} frame_t;

	// Ten to the power n, for elaboration-time limits.
	function automatic int unsigned pow10(input int n);
		int unsigned acc;
		acc = 1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 10;
		end
		return acc;
	endfunction

	// Multiple j of ten to the power sel. Powers beyond what a 16-bit value can
	// reach return all ones, which no remainder can match.
	function automatic logic [16:0] pow_multiple(input logic [2:0] sel, input logic [3:0] j);
		logic [16:0] base;
		case (sel)
			3'd0: base = 17'd1;
			3'd1: base = 17'd10;
			3'd2: base = 17'd100;
			3'd3: base = 17'd1000;
			3'd4: base = 17'd10000;
			default: base = '1;
		endcase
		if (sel > MAX_POW_SEL) begin
			return '1;
		end
		return 17'(base * {13'd0, j});
	endfunction

	// Seven-segment pattern of one decimal digit.
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'd0: pat = 8'hEB;
			4'd1: pat = 8'h0A;
			4'd2: pat = 8'hAD;
			4'd3: pat = 8'h8F;
			4'd4: pat = 8'h4E;
			4'd5: pat = 8'hC7;
			4'd6: pat = 8'hE7;
			4'd7: pat = 8'h8A;
			4'd8: pat = 8'hEF;
			4'd9: pat = 8'hCF;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// ----- hw/rtl/slvf_digit.sv -----
// Extracts one decimal digit from a remainder, most significant first.
// Compares against the nine multiples of the selected power of ten in parallel.
// Depends on slvf_pkg.
module slvf_digit (
	input  logic [15:0] rem,
	input  logic [2:0]  pow_sel,
	output logic [3:0]  digit,
	output logic [15:0] rem_next
);

	logic [16:0] sub_amt;
	logic [16:0] rem_ext;
	logic [16:0] diff;

	// The largest multiple that still fits gives the digit and the amount to remove.
	always_comb begin
		rem_ext = {1'b0, rem};
		digit   = 4'd0;
		sub_amt = 17'd0;
		for (int j = 1; j <= 9; j++) begin
			if (rem_ext >= slvf_pkg::pow_multiple(pow_sel, 4'(j))) begin
				digit   = 4'(j);
				sub_amt = slvf_pkg::pow_multiple(pow_sel, 4'(j));
			end
		end
		diff     = rem_ext - sub_amt;
		rem_next = diff[15:0];
	end

endmodule

// ----- hw/rtl/slvf_seq.sv -----
// Frame sequencer: walks the digits of a value request, two frames per digit,
// or sends one command frame, and holds the result register.
// Depends on slvf_pkg and slvf_digit.
module slvf_seq #(
	parameter int DIGIT_COUNT = slvf_pkg::DIGIT_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  slvf_pkg::req_t    req,
	output logic              req_take,
	output logic              strobe_q,
	output slvf_pkg::frame_t  frame_q
);

	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);
	localparam logic [2:0] TOP_POW = 3'(DIGIT_COUNT - 1);
	localparam bit HAS_POINT = (DIGIT_COUNT >= 3);
	localparam logic [IDX_W-1:0] POINT_IDX = HAS_POINT ? IDX_W'(DIGIT_COUNT - 3) : '0;

	logic             active_q;
	logic             half_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      rem_q;
	logic             point_q;
	logic [3:0]       lo_nib_q;

	logic             cur_cmd;
	logic             cur_val;
	logic             cur_half;
	logic [IDX_W-1:0] cur_idx;
	logic [15:0]      cur_rem;
	logic             cur_point;
	logic [2:0]       pow_sel;
	logic [3:0]       digit;
	logic [15:0]      rem_next;
	logic [7:0]       pattern;
	logic [5:0]       addr;
	logic [3:0]       nibble;
	logic             is_last;
	logic             emit;
	slvf_pkg::frame_t frame_d;

	// A new request starts only once the previous one has sent its last frame.
	assign req_take = req_valid && !active_q;

	// Select the work of this cycle: the first frame of a new request or the next
	// frame of the running one.
	always_comb begin
		cur_cmd   = req_take && req.req_type;
		cur_val   = req_take ? !req.req_type : active_q;
		cur_half  = req_take ? 1'b0 : half_q;
		cur_idx   = req_take ? '0 : idx_q;
		cur_rem   = req_take ? req.value : rem_q;
		cur_point = req_take ? req.point_on : point_q;
		pow_sel   = TOP_POW - 3'(cur_idx);
	end

	slvf_digit u_digit (
		.rem      (cur_rem),
		.pow_sel  (pow_sel),
		.digit    (digit),
		.rem_next (rem_next)
	);

	// Segment pattern, frame address and frame assembly.
	always_comb begin
		pattern = slvf_pkg::seg_pattern(digit);
		if (HAS_POINT && cur_point && (cur_idx == POINT_IDX)) begin
			pattern = pattern | slvf_pkg::POINT_BIT;
		end
		addr    = 6'({cur_idx, cur_half});
		nibble  = cur_half ? lo_nib_q : pattern[7:4];
		is_last = cur_cmd || (cur_val && cur_half && (cur_idx == LAST_IDX));
		emit    = cur_cmd || cur_val;
		if (cur_cmd) begin
			frame_d.word   = {1'b0, slvf_pkg::CMD_PREFIX, req.command_code};
			frame_d.length = slvf_pkg::CMD_LEN;
		end else begin
			frame_d.word   = {slvf_pkg::DATA_PREFIX, addr, nibble};
			frame_d.length = slvf_pkg::DATA_LEN;
		end
		frame_d.last = is_last;
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			half_q   <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			active_q <= cur_val && !is_last;
			strobe_q <= emit;
			if (cur_val) begin
				half_q <= !cur_half;
				idx_q  <= cur_half ? cur_idx + 1'b1 : cur_idx;
			end
		end
	end

	// Digit remainder and the lower nibble waiting for the odd-address frame.
	always_ff @(posedge clk) begin
		if (cur_val && !cur_half) begin
			rem_q    <= rem_next;
			lo_nib_q <= pattern[3:0];
			point_q  <= cur_point;
		end
		if (emit) begin
			frame_q <= frame_d;
		end
	end

endmodule

// ----- hw/rtl/segment_lcd_value_framer.sv -----
// Top level of the segment LCD value framer: input register with saturation,
// frame sequencer and result register.
// Depends on slvf_pkg and slvf_seq.
//
//  channel   handshake             payload
//  request   start / busy          req_type, value, point_on, command_code
//  frames    strobe (no stall)     frame_word, frame_length, last_frame
//
// A value request gives 2*DIGIT_COUNT frames on consecutive cycles (8 by
// default); a command request gives one frame. The sequencer, one frame per
// cycle, sets the rate: it takes no new request until the last frame of the
// running one has been issued. An accepted request passes through the input
// register and the sequencer's result register before its first frame shows.
// busy is high while the input register holds a request the sequencer has not
// yet started. Reset clears the input register and the sequencer.
module segment_lcd_value_framer #(
	parameter int DIGIT_COUNT = slvf_pkg::DIGIT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] value,
	input  logic        point_on,
	input  logic [7:0]  command_code,
	output logic        strobe,
	output logic [12:0] frame_word,
	output logic [3:0]  frame_length,
	output logic        last_frame
);

	localparam int unsigned MAX_VALUE = (DIGIT_COUNT >= 5) ? 32'd65535 :
		slvf_pkg::pow10(DIGIT_COUNT) - 1;

	logic             valid_s1;
	slvf_pkg::req_t   req_s1;
	logic             accept;
	logic             take;
	logic [15:0]      value_sat;
	slvf_pkg::frame_t frame_q;

	// A transaction is taken when the input register is empty or being drained.
	assign busy   = valid_s1 && !take;
	assign accept = start && !busy;

	// Saturate values that need more digits than the display has.
	assign value_sat = (value > 16'(MAX_VALUE)) ? 16'(MAX_VALUE) : value;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type     <= req_type;
			req_s1.value        <= value_sat;
			req_s1.point_on     <= point_on;
			req_s1.command_code <= command_code;
		end
	end

	slvf_seq #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s1),
		.req       (req_s1),
		.req_take  (take),
		.strobe_q  (strobe),
		.frame_q   (frame_q)
	);

	assign frame_word   = frame_q.word;
	assign frame_length = frame_q.length;
	assign last_frame   = frame_q.last;

endmodule

// ----- hw/rtl/slvf_checker.sv -----
// Port-level checks for the segment LCD value framer, attached by bind.
// Depends on slvf_pkg and segment_lcd_value_framer.
module slvf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [12:0] frame_word,
	input logic [3:0]  frame_length,
	input logic        last_frame
);

	// Frames of one value transaction leave on consecutive cycles.
	a_frames_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_frame |=> strobe)
		else $error("frame sequence broken before its last frame");

	// A command frame is always the only, hence last, frame of its transaction.
	a_cmd_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (frame_length == slvf_pkg::CMD_LEN) |-> last_frame &&
		(frame_word[12:8] == {1'b0, slvf_pkg::CMD_PREFIX}))
		else $error("malformed command frame");

	// A data frame carries the data prefix and a length of thirteen.
	a_data_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (frame_length != slvf_pkg::CMD_LEN) |->
		(frame_length == slvf_pkg::DATA_LEN) &&
		(frame_word[12:10] == slvf_pkg::DATA_PREFIX))
		else $error("malformed data frame");

	// Quiet cycles with no accepted transaction leave nothing to send next.
	a_no_early_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe && !(start && !busy) ##1 !strobe && !(start && !busy) |=> !strobe)
		else $error("frame without a pending transaction");

endmodule

bind segment_lcd_value_framer slvf_checker u_slvf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.frame_word   (frame_word),
	.frame_length (frame_length),
	.last_frame   (last_frame)
);
